### rtl/crc16_frame_receiver_assert.svh
// crc16_frame_receiver_assert.svh: assertion macros for the frame receiver checker
// depends on a clk and an active-high rst in the scope of each use
`ifndef CRC16_FRAME_RECEIVER_ASSERT_SVH
`define CRC16_FRAME_RECEIVER_ASSERT_SVH

// checked property, masked while reset is high
`define CFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, live through reset as well
`define CFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cfr_pkg.sv
// cfr_pkg: types, constants and the crc step shared by the frame receiver
// no dependencies
package cfr_pkg;

  // parameter defaults
  localparam int FRAME_STORE_BYTES_DEF = 70;
  localparam int MAX_PAYLOAD_BYTES_DEF = 64;
  // most payload words one frame can report
  localparam int PAY_CAP = 64;

  // register reset values and fixed constants
  localparam logic [7:0]  SYNC_RESET    = 8'hAA;
  localparam logic [11:0] TIMEOUT_RESET = 12'd2000;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [11:0] MS_SAT        = 12'hFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC    = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_PAUSE   = 2'd2;

  // event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_GOOD    = 2'd1;
  localparam logic [1:0] EV_CRC_ERR = 2'd2;

  typedef enum logic [2:0] {
    H_WAIT, H_TYPE, H_LEN, H_SEQ, H_PAY, H_CRCLO, H_CRCHI
  } hunt_t;

  typedef enum logic [1:0] {
    E_IDLE, E_FETCH, E_SEND
  } emit_t;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [11:0] link_timeout_ms;
    logic        receive_paused;
  } cfg_t;

  // one finished input item, waiting to be sent out
  typedef struct packed {
    logic [1:0]  ev;
    logic [7:0]  frame_type;
    logic [7:0]  frame_length;
    logic [7:0]  frame_seq;
    logic        ovf;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
    logic        link_up;
    logic        payload;
    logic [6:0]  count;
  } desc_t;

  // msb-first crc-16-ccitt over one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### rtl/cfr_ram.sv
// cfr_ram: payload byte store, one write port and one registered read port
// depends on nothing
module cfr_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/cfr_parser.sv
// cfr_parser: frame hunt, running crc, counters and link timer
// depends on cfr_pkg; writes payload bytes into cfr_ram
module cfr_parser
  import cfr_pkg::*;
#(
  parameter int FRAME_STORE_BYTES = FRAME_STORE_BYTES_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  parameter int PAY_DEPTH = (MAX_PAYLOAD_BYTES < PAY_CAP) ? MAX_PAYLOAD_BYTES : PAY_CAP,
  parameter int AW = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_mode,
  input  logic [7:0]    in_byte,
  input  logic          ram_busy,
  input  logic          desc_take,
  output logic          desc_valid,
  output desc_t         desc,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  localparam int SIW = $clog2(FRAME_STORE_BYTES + 1);
  localparam int IW  = (SIW > 9) ? SIW : 9;

  hunt_t       hunt, hunt_next;
  logic [IW-1:0] store_index, store_index_next;
  logic [7:0]  held_type, held_length, held_seq;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte;
  logic [31:0] good_count, good_count_next;
  logic [31:0] bad_count, bad_count_next;
  logic [11:0] ms_since_good, ms_since_good_next;
  logic        seen_good, seen_good_next;
  desc_t       desc_next;

  logic          accepted, live, byte_item, tick_item;
  logic [IW-1:0] idx_after, pay_k;
  logic          ovf_hit, done, good, pay_ok;
  logic [15:0]   crc_fed;

  // handshake: stall while a result waits, or payload writes could hit the readout
  assign in_ready  = !desc_valid && !(hunt == H_PAY && ram_busy);
  assign accepted  = in_valid && in_ready;
  assign live      = accepted && !cfg.receive_paused;
  assign byte_item = live && !in_mode;
  assign tick_item = live && in_mode;

  // per-byte frame decode
  assign idx_after = (hunt == H_WAIT) ? '0 : store_index + IW'(1);
  assign ovf_hit   = byte_item && (hunt != H_WAIT) && (idx_after >= IW'(FRAME_STORE_BYTES));
  assign done      = byte_item && (hunt == H_CRCHI);
  assign good      = done && (running_crc == {in_byte, crc_low_byte});
  assign crc_fed   = crc_feed(running_crc, in_byte);
  assign pay_k     = store_index - IW'(3);
  assign pay_ok    = good && (held_length != 8'd0) && ({1'b0, held_length} <= 9'(PAY_DEPTH));

  // payload store write
  assign wr_en   = byte_item && (hunt == H_PAY) && (pay_k < IW'(PAY_DEPTH));
  assign wr_addr = pay_k[AW-1:0];
  assign wr_data = in_byte;

  // hunt next state
  always_comb begin
    hunt_next = hunt;
    if (byte_item) begin
      unique case (hunt)
        H_WAIT:  if (in_byte == cfg.sync_byte) hunt_next = H_TYPE;
        H_TYPE:  hunt_next = H_LEN;
        H_LEN:   hunt_next = H_SEQ;
        H_SEQ:   hunt_next = (held_length != 8'd0) ? H_PAY : H_CRCLO;
        H_PAY: begin
          if (idx_after >= IW'(held_length) + IW'(3)) hunt_next = H_CRCLO;
        end
        H_CRCLO: hunt_next = H_CRCHI;
        H_CRCHI: hunt_next = H_WAIT;
        default: hunt_next = H_WAIT;
      endcase
      if (ovf_hit) hunt_next = H_WAIT;
    end
  end

  // datapath next values
  always_comb begin
    store_index_next = store_index;
    running_crc_next = running_crc;
    if (byte_item) begin
      store_index_next = (ovf_hit || done) ? '0 : idx_after;
      if (hunt == H_WAIT) begin
        if (in_byte == cfg.sync_byte) running_crc_next = CRC_INIT;
      end else if (hunt == H_TYPE || hunt == H_LEN || hunt == H_SEQ || hunt == H_PAY) begin
        running_crc_next = crc_fed;
      end
    end
    good_count_next = good_count + 32'(good);
    bad_count_next  = bad_count + 32'(done && !good) + 32'(ovf_hit);
    seen_good_next  = seen_good || good;
    ms_since_good_next = ms_since_good;
    if (good) begin
      ms_since_good_next = '0;
    end else if (tick_item && ms_since_good != MS_SAT) begin
      ms_since_good_next = ms_since_good + 12'd1;
    end
  end

  // result descriptor for this item
  always_comb begin
    desc_next.ev           = done ? (good ? EV_GOOD : EV_CRC_ERR) : EV_NONE;
    desc_next.frame_type   = done ? held_type : 8'd0;
    desc_next.frame_length = done ? held_length : 8'd0;
    desc_next.frame_seq    = done ? held_seq : 8'd0;
    desc_next.ovf          = ovf_hit;
    desc_next.good_frames  = good_count_next;
    desc_next.bad_frames   = bad_count_next;
    desc_next.link_up      = seen_good_next && (ms_since_good_next < cfg.link_timeout_ms);
    desc_next.payload      = pay_ok;
    desc_next.count        = pay_ok ? held_length[6:0] : 7'd1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hunt          <= H_WAIT;
      store_index   <= '0;
      held_type     <= '0;
      held_length   <= '0;
      held_seq      <= '0;
      running_crc   <= CRC_INIT;
      crc_low_byte  <= '0;
      good_count    <= '0;
      bad_count     <= '0;
      ms_since_good <= '0;
      seen_good     <= 1'b0;
      desc_valid    <= 1'b0;
    end else begin
      hunt        <= hunt_next;
      store_index <= store_index_next;
      running_crc <= running_crc_next;
      if (byte_item && hunt == H_TYPE)  held_type    <= in_byte;
      if (byte_item && hunt == H_LEN)   held_length  <= in_byte;
      if (byte_item && hunt == H_SEQ)   held_seq     <= in_byte;
      if (byte_item && hunt == H_CRCLO) crc_low_byte <= in_byte;
      good_count    <= good_count_next;
      bad_count     <= bad_count_next;
      ms_since_good <= ms_since_good_next;
      seen_good     <= seen_good_next;
      if (live) begin
        desc_valid <= 1'b1;
      end else if (desc_take) begin
        desc_valid <= 1'b0;
      end
    end
  end

  // descriptor payload, no reset
  always_ff @(posedge clk) begin
    if (live) begin
      desc <= desc_next;
    end
  end

endmodule

### rtl/cfr_emitter.sv
// cfr_emitter: turns descriptors into output words, reading payload from cfr_ram
// depends on cfr_pkg
module cfr_emitter
  import cfr_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  parameter int PAY_DEPTH = (MAX_PAYLOAD_BYTES < PAY_CAP) ? MAX_PAYLOAD_BYTES : PAY_CAP,
  parameter int AW = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          desc_valid,
  input  desc_t         desc,
  output logic          desc_take,
  output logic          busy,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [103:0]  out_data,
  output logic [2:0]    out_user,
  output logic          out_last
);

  emit_t      state, state_next;
  desc_t      cur;
  logic [6:0] k, k_plus;
  logic [7:0] o_byte;
  logic [5:0] o_index;
  logic       o_pv;
  logic       o_last;

  assign k_plus = k + 7'd1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      E_IDLE:  if (desc_valid) state_next = desc.payload ? E_FETCH : E_SEND;
      E_FETCH: state_next = E_SEND;
      E_SEND:  if (out_ready) state_next = o_last ? E_IDLE : E_FETCH;
      default: state_next = E_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    desc_take = (state == E_IDLE) && desc_valid;
    rd_en     = (desc_take && desc.payload) || ((state == E_SEND) && out_ready && !o_last);
    rd_addr   = desc_take ? '0 : k_plus[AW-1:0];
    out_valid = (state == E_SEND);
    busy      = (state != E_IDLE) && cur.payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output word registers
  always_ff @(posedge clk) begin
    if (desc_take) begin
      cur     <= desc;
      k       <= '0;
      o_byte  <= '0;
      o_index <= '0;
      o_pv    <= 1'b0;
      o_last  <= 1'b1;
    end else if (state == E_FETCH) begin
      o_byte  <= rd_data;
      o_index <= k[5:0];
      o_pv    <= 1'b1;
      o_last  <= (k_plus == cur.count);
    end else if (state == E_SEND && out_ready && !o_last) begin
      k <= k_plus;
    end
  end

  // pack word fields, highest first
  assign out_data = {cur.link_up, cur.bad_frames, cur.good_frames, cur.ovf, o_index, o_byte,
                     cur.frame_seq, cur.frame_length, cur.frame_type};
  assign out_user = {o_pv, cur.ev};
  assign out_last = o_last;

endmodule

### rtl/crc16_frame_receiver.sv
// crc16_frame_receiver: deframes sync/type/length/seq/payload/crc16 frames from uart bytes
// output path: a single-word result passes the descriptor register, then the emitter state,
//   before m_tvalid; the first payload word of a good frame also passes a payload ram read
// input: no word is taken while a result waits; payload words each pass fetch and send,
//   and after the word that follows a frame's crc the input stalls until that readout ends
// reset: synchronous rst clears hunt state, counters, link timer and handshake state
module crc16_frame_receiver
  import cfr_pkg::*;
#(
  parameter int FRAME_STORE_BYTES = FRAME_STORE_BYTES_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // rx_byte
  input  logic         s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  // frame_type, frame_length, frame_seq, payload_byte, payload_index, overflow,
  // good_frames, bad_frames, link_up
  output logic [103:0] m_tdata,
  output logic [2:0]   m_tuser,   // event_res, payload_valid
  output logic         m_tlast,   // last
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [11:0]  cfg_data
);

  localparam int PAY_DEPTH = (MAX_PAYLOAD_BYTES < PAY_CAP) ? MAX_PAYLOAD_BYTES : PAY_CAP;
  localparam int AW = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

  cfg_t          cfg;
  desc_t         desc;
  logic          desc_valid, desc_take, ram_busy;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte       <= SYNC_RESET;
      cfg.link_timeout_ms <= TIMEOUT_RESET;
      cfg.receive_paused  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC:    cfg.sync_byte       <= cfg_data[7:0];
        CFG_TIMEOUT: cfg.link_timeout_ms <= cfg_data;
        CFG_PAUSE:   cfg.receive_paused  <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  cfr_parser #(
    .FRAME_STORE_BYTES(FRAME_STORE_BYTES),
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
    .PAY_DEPTH(PAY_DEPTH),
    .AW(AW)
  ) u_parser (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_mode(s_tuser),
    .in_byte(s_tdata),
    .ram_busy(ram_busy),
    .desc_take(desc_take),
    .desc_valid(desc_valid),
    .desc(desc),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  cfr_ram #(
    .DEPTH(PAY_DEPTH),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  cfr_emitter #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
    .PAY_DEPTH(PAY_DEPTH),
    .AW(AW)
  ) u_emitter (
    .clk(clk),
    .rst(rst),
    .desc_valid(desc_valid),
    .desc(desc),
    .desc_take(desc_take),
    .busy(ram_busy),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data(m_tdata),
    .out_user(m_tuser),
    .out_last(m_tlast)
  );

endmodule

### rtl/cfr_checker.sv
// cfr_checker: port-level assertions on the frame receiver, bound to the top level
// depends on cfr_pkg and crc16_frame_receiver_assert.svh
`include "crc16_frame_receiver_assert.svh"

module cfr_checker
  import cfr_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [2:0]   m_tuser,
  input logic         m_tlast
);

  // a stalled output word stays valid
  `CFR_ASSERT(a_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "stalled word dropped")

  // a stalled output word holds its data
  `CFR_ASSERT(a_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled word changed")

  // reset leaves no word on the output
  `CFR_ASSERT_RST(a_reset_idle, rst |=> !m_tvalid, "output valid right after reset")

  // payload bytes only come with a good frame
  `CFR_ASSERT(a_pay_good, m_tvalid && m_tuser[2] |-> m_tuser[1:0] == EV_GOOD, "stray payload")

  // every word that is not a good frame is the only result of its input
  `CFR_ASSERT(a_single_last, m_tvalid && m_tuser[1:0] != EV_GOOD |-> m_tlast, "missing last")

endmodule

bind crc16_frame_receiver cfr_checker u_cfr_checker (.*);

### tb/crc16_frame_receiver_tb.sv
// crc16_frame_receiver_tb: self-checking bench for the frame receiver
// drives uart byte and tick words, predicts every result word and checks it field by field
// depends on cfr_pkg and crc16_frame_receiver
`timescale 1ns / 100ps

module crc16_frame_receiver_tb;
  import cfr_pkg::*;

  // one predicted result word
  typedef struct {
    logic [1:0]  ev;
    logic [7:0]  ftype;
    logic [7:0]  flen;
    logic [7:0]  fseq;
    logic [7:0]  pbyte;
    logic [5:0]  pidx;
    logic        pvalid;
    logic        is_last;
    logic        ovf;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
    logic        link;
  } frame_result_t;

  // deframer model plus the queue of results it predicts
  class frame_scoreboard;
    logic [7:0]    sync_val;
    logic [11:0]   timeout_ms;
    logic          paused;
    hunt_t         hunt;
    int unsigned   stored;
    logic [7:0]    f_type;
    logic [7:0]    f_len;
    logic [7:0]    f_seq;
    logic [7:0]    crc_lo;
    logic [15:0]   crc;
    logic [7:0]    pay[PAY_CAP];
    logic [31:0]   good_cnt;
    logic [31:0]   bad_cnt;
    logic [11:0]   ms_count;
    logic          had_good;
    frame_result_t pending_results[$];
    int            errors;

    function new();
      sync_val   = SYNC_RESET;
      timeout_ms = TIMEOUT_RESET;
      paused     = 1'b0;
      hunt       = H_WAIT;
      stored     = 0;
      f_type     = 8'h00;
      f_len      = 8'h00;
      f_seq      = 8'h00;
      crc_lo     = 8'h00;
      crc        = CRC_INIT;
      good_cnt   = 32'd0;
      bad_cnt    = 32'd0;
      ms_count   = 12'd0;
      had_good   = 1'b0;
      errors     = 0;
    endfunction

    // msb-first ccitt update over one byte
    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      repeat (8) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      return r;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] val);
      unique case (idx)
        CFG_SYNC:    sync_val = val[7:0];
        CFG_TIMEOUT: timeout_ms = val;
        CFG_PAUSE:   paused = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void add_result(logic [1:0] ev, logic hdr, logic [7:0] pb, logic [5:0] pi,
                             logic pv, logic lst, logic ovf);
      frame_result_t r;
      r.ev       = ev;
      r.ftype    = hdr ? f_type : 8'h00;
      r.flen     = hdr ? f_len : 8'h00;
      r.fseq     = hdr ? f_seq : 8'h00;
      r.pbyte    = pb;
      r.pidx     = pi;
      r.pvalid   = pv;
      r.is_last  = lst;
      r.ovf      = ovf;
      r.good_cnt = good_cnt;
      r.bad_cnt  = bad_cnt;
      r.link     = had_good && (ms_count < timeout_ms);
      pending_results.push_back(r);
    endfunction

    // accepted input word: step the hunt and queue what it produces
    function void note_word(logic mode, logic [7:0] b);
      logic done;
      logic good;
      logic ovf;
      int unsigned k;
      done = 1'b0;
      good = 1'b0;
      ovf  = 1'b0;
      if (paused) return;
      if (mode) begin
        if (ms_count != MS_SAT) ms_count++;
        add_result(EV_NONE, 1'b0, 8'h00, 6'd0, 1'b0, 1'b1, 1'b0);
        return;
      end
      case (hunt)
        H_WAIT: begin
          if (b == sync_val) begin
            stored = 0;
            crc    = CRC_INIT;
            hunt   = H_TYPE;
          end
        end
        H_TYPE: begin
          f_type = b;
          crc    = crc_step(crc, b);
          stored++;
          hunt   = H_LEN;
        end
        H_LEN: begin
          f_len = b;
          crc   = crc_step(crc, b);
          stored++;
          hunt  = H_SEQ;
        end
        H_SEQ: begin
          f_seq = b;
          crc   = crc_step(crc, b);
          stored++;
          hunt  = (f_len != 0) ? H_PAY : H_CRCLO;
        end
        H_PAY: begin
          k = stored - 3;
          if (k < MAX_PAYLOAD_BYTES_DEF) pay[k] = b;
          crc = crc_step(crc, b);
          stored++;
          if (stored >= 3 + f_len) hunt = H_CRCLO;
        end
        H_CRCLO: begin
          crc_lo = b;
          stored++;
          hunt   = H_CRCHI;
        end
        default: begin
          stored++;
          done = 1'b1;
          good = (crc == {b, crc_lo});
          hunt = H_WAIT;
        end
      endcase
      if (done) begin
        if (good) begin
          good_cnt++;
          ms_count = 12'd0;
          had_good = 1'b1;
        end else begin
          bad_cnt++;
        end
      end
      // frame store full: drop the hunt and count it as bad
      if (stored >= FRAME_STORE_BYTES_DEF) begin
        hunt   = H_WAIT;
        stored = 0;
        bad_cnt++;
        ovf    = 1'b1;
      end
      if (done) stored = 0;
      if (!done) begin
        add_result(EV_NONE, 1'b0, 8'h00, 6'd0, 1'b0, 1'b1, ovf);
      end else if (!good) begin
        add_result(EV_CRC_ERR, 1'b1, 8'h00, 6'd0, 1'b0, 1'b1, ovf);
      end else if (f_len == 0 || f_len > MAX_PAYLOAD_BYTES_DEF || f_len > PAY_CAP) begin
        add_result(EV_GOOD, 1'b1, 8'h00, 6'd0, 1'b0, 1'b1, ovf);
      end else begin
        for (int i = 0; i < f_len; i++)
          add_result(EV_GOOD, 1'b1, pay[i], i[5:0], 1'b1, (i + 1 == f_len), ovf);
      end
    endfunction

    function void cmp_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    // accepted result word against the oldest prediction
    function void check_result(logic [103:0] d, logic [2:0] u, logic l);
      frame_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, got tdata %h tuser %h tlast %b",
                 $time, d, u, l);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      cmp_field("event_res", 32'(e.ev), 32'(u[1:0]));
      cmp_field("payload_valid", 32'(e.pvalid), 32'(u[2]));
      cmp_field("last", 32'(e.is_last), 32'(l));
      cmp_field("frame_type", 32'(e.ftype), 32'(d[7:0]));
      cmp_field("frame_length", 32'(e.flen), 32'(d[15:8]));
      cmp_field("frame_seq", 32'(e.fseq), 32'(d[23:16]));
      cmp_field("payload_byte", 32'(e.pbyte), 32'(d[31:24]));
      cmp_field("payload_index", 32'(e.pidx), 32'(d[37:32]));
      cmp_field("overflow", 32'(e.ovf), 32'(d[38]));
      cmp_field("good_frames", e.good_cnt, d[70:39]);
      cmp_field("bad_frames", e.bad_cnt, d[102:71]);
      cmp_field("link_up", 32'(e.link), 32'(d[103]));
    endfunction
  endclass

  // dut ports, inputs known from the start
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata = 8'h00;    // rx_byte
  logic         s_tuser = 1'b0;     // mode
  logic         m_tready = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = CFG_SYNC;
  logic [11:0]  cfg_data = 12'd0;
  logic         s_tready;
  logic         m_tvalid;
  // frame_type, frame_length, frame_seq, payload_byte, payload_index, overflow,
  // good_frames, bad_frames, link_up
  logic [103:0] m_tdata;
  logic [2:0]   m_tuser;            // event_res, payload_valid
  logic         m_tlast;            // last

  frame_scoreboard sb;
  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;
  int   words_sent = 0;

  crc16_frame_receiver u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: check accepted words, stall at random while rx_idle is set
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    m_tready <= !rx_idle || ($urandom_range(99) >= 29);
  end

  // one input word, with a random gap ahead of it while tx_idle is set
  task automatic send_word(input logic mode, input logic [7:0] b);
    if (tx_idle && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 29);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_word(mode, b);
    words_sent++;
  endtask

  // uart byte, now and then preceded by a tick
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(15) == 0) send_word(1'b1, 8'($urandom_range(255)));
    send_word(1'b0, b);
  endtask

  task automatic send_frame(input logic [7:0] sync, input logic [7:0] ftype,
                            input logic [7:0] flen, input logic [7:0] seq,
                            input logic bad_crc);
    logic [7:0]  body[$];
    logic [15:0] c;
    body = {ftype, flen, seq};
    for (int i = 0; i < flen; i++) body.push_back(8'($urandom_range(255)));
    c = CRC_INIT;
    foreach (body[i]) c = frame_scoreboard::crc_step(c, body[i]);
    if (bad_crc) c = c ^ (16'd1 << $urandom_range(15));
    send_byte(sync);
    foreach (body[i]) send_byte(body[i]);
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  // hold off input until every predicted result has come, then settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // mostly well-formed frames with random content, plus ticks, noise and cut frames
  task automatic run_random(input int target);
    int         start;
    int         pick;
    int         k;
    logic [7:0] len;
    start = words_sent;
    while (words_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        k = $urandom_range(99);
        if (k < 78)      len = 8'($urandom_range(8));
        else if (k < 90) len = 8'($urandom_range(63, 9));
        else if (k < 94) len = 8'd64;
        else if (k < 97) len = 8'd65;
        else             len = 8'($urandom_range(80, 66));
        send_frame(sb.sync_val, 8'($urandom_range(255)), len, 8'($urandom_range(255)),
                   $urandom_range(4) == 0);
      end else if (pick < 75) begin
        send_byte(sb.sync_val);
        repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)));
      end else if (pick < 88) begin
        repeat ($urandom_range(8, 1)) send_word(1'b1, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: tick, byte extremes, empty frame, crc error, sync value inside a frame
    send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hFF);
    send_frame(SYNC_RESET, 8'h00, 8'd0, 8'hFF, 1'b0);
    send_frame(SYNC_RESET, 8'hFF, 8'd1, 8'h00, 1'b1);
    send_frame(SYNC_RESET, SYNC_RESET, 8'd2, SYNC_RESET, 1'b0);
    wait_idle();

    // short timeout, sync of all zeros
    write_reg(CFG_TIMEOUT, 12'd1);
    write_reg(CFG_SYNC, 12'h000);
    run_random(55);
    wait_idle();

    // longest timeout, sync of all ones, no idling on either side
    write_reg(CFG_SYNC, 12'h0FF);
    write_reg(CFG_TIMEOUT, 12'hFFF);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_frame(sb.sync_val, 8'($urandom_range(255)), 8'd64, 8'($urandom_range(255)), 1'b0);
    send_frame(sb.sync_val, 8'($urandom_range(255)), 8'd65, 8'($urandom_range(255)), 1'b0);
    run_random(55);
    wait_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // paused receiver ignores every word
    write_reg(CFG_PAUSE, 12'd1);
    repeat (30) send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
    wait_idle();
    write_reg(CFG_PAUSE, 12'd0);

    // zero timeout keeps the link down, random sync value
    write_reg(CFG_TIMEOUT, 12'd0);
    write_reg(CFG_SYNC, 12'($urandom_range(255)));
    run_random(55);
    wait_idle();

    // back to the usual sync value with a few-millisecond timeout
    write_reg(CFG_TIMEOUT, 12'd3);
    write_reg(CFG_SYNC, {4'h0, SYNC_RESET});
    run_random(55);
    wait_idle();

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
